// ===== design/tdbl_pkg.sv =====
// Shared widths, codes, defaults and state type for the tree distance block.
package tdbl_pkg;

    localparam int NODE_W          = 10;
    localparam int DEPTH_W         = 11;
    localparam int DIST_W          = 11;
    localparam int NODE_COUNT_DEF  = 1024;
    localparam int LIFT_LEVELS_DEF = 10;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 11'd2047;
    localparam logic [DIST_W-1:0]  DIST_MAX  = 11'd2047;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_L_DEP,
        ST_L_ANC,
        ST_Q_DEP,
        ST_Q_UP,
        ST_Q_UPD,
        ST_Q_PAIR,
        ST_Q_OUT
    } t_state;

endpackage

// ===== design/tdbl_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
module tdbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= mem[i_raddr0];
        o_rdata1 <= mem[i_raddr1];
    end

endmodule

// ===== design/tree_distance_binary_lifting.sv =====
// Tree distance by binary lifting. Node depths (held as depth plus one) and the
// 2^j ancestor table sit in two RAMs with registered read data; node 0
// is the sentinel above the root and reads as zero in both without being stored.
// A load beat (parent loaded first, 0 for the root) keeps the input stalled
// until its table entries are written: the parent's depth is read in the accept
// cycle, then one ancestor read per level, each level's address coming from the
// previous level's data. A query keeps it stalled through these steps: comparing
// both depths, then per level while lifting the deeper node an ancestor read and
// a depth read of that ancestor, then per level while lifting both nodes together
// one read on each of the two read ports, and last handing the distance to the
// output register. It is shorter when the depths match or the lifted node lands
// on the other one, and longer while an earlier distance is still held in a
// stalled output register. Loads give no result; a load of node 0 or of a node
// number at or beyond NODE_COUNT is ignored, and a query treats such a node
// number as node 0. A new beat is taken as soon as the sequencer is idle, even
// while a distance waits in the output register.
module tree_distance_binary_lifting #(
    parameter int NODE_COUNT  = tdbl_pkg::NODE_COUNT_DEF,
    parameter int LIFT_LEVELS = tdbl_pkg::LIFT_LEVELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic [tdbl_pkg::NODE_W-1:0]  i_node,
    input  logic [tdbl_pkg::NODE_W-1:0]  i_other_node,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tdbl_pkg::DIST_W-1:0]  o_distance
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(LIFT_LEVELS);
    localparam int AW = NW + LW;
    localparam int RW = LIFT_LEVELS + 2;
    localparam logic [LW-1:0] LAST_LVL = LW'(LIFT_LEVELS - 1);

    tdbl_pkg::t_state r_state, n_state;

    logic [NW-1:0]                    r_a, n_a;
    logic [NW-1:0]                    r_b, n_b;
    logic [NW-1:0]                    r_up, n_up;
    logic [tdbl_pkg::DEPTH_W-1:0]     r_da, n_da;
    logic [LW-1:0]                    r_lvl, n_lvl;
    logic [RW-1:0]                    r_ret, n_ret;
    logic                             r_out_valid, n_out_valid;
    logic [tdbl_pkg::DIST_W-1:0]      r_distance, n_distance;

    // RAM ports
    logic                             dep_we;
    logic [NW-1:0]                    dep_waddr, dep_ra0, dep_ra1;
    logic [tdbl_pkg::DEPTH_W-1:0]     dep_wdata, dep_q0, dep_q1;
    logic                             anc_we;
    logic [AW-1:0]                    anc_waddr, anc_ra0, anc_ra1;
    logic [NW-1:0]                    anc_wdata, anc_q0, anc_q1;

    // sentinel / forwarding flags for the data coming back next cycle
    logic                             r_dz0, r_dz1, r_az0, r_az1, r_afwd;
    logic [NW-1:0]                    r_afwd_data;

    logic [tdbl_pkg::DEPTH_W-1:0]     dq0, dq1;
    logic [NW-1:0]                    aq0, aq1;

    logic                             node_ok, other_ok;
    logic [NW-1:0]                    idx_node, idx_other;
    logic [NW-1:0]                    b_sel, a_new, b_new;
    logic                             up_take;

    tdbl_ram #(
        .WIDTH (tdbl_pkg::DEPTH_W),
        .DEPTH (NODE_COUNT)
    ) u_depth_ram (
        .i_clk    (i_clk),
        .i_we     (dep_we),
        .i_waddr  (dep_waddr),
        .i_wdata  (dep_wdata),
        .i_raddr0 (dep_ra0),
        .i_raddr1 (dep_ra1),
        .o_rdata0 (dep_q0),
        .o_rdata1 (dep_q1)
    );

    tdbl_ram #(
        .WIDTH (NW),
        .DEPTH (2 ** AW)
    ) u_anc_ram (
        .i_clk    (i_clk),
        .i_we     (anc_we),
        .i_waddr  (anc_waddr),
        .i_wdata  (anc_wdata),
        .i_raddr0 (anc_ra0),
        .i_raddr1 (anc_ra1),
        .o_rdata0 (anc_q0),
        .o_rdata1 (anc_q1)
    );

    assign node_ok   = 32'(i_node) < 32'(NODE_COUNT);
    assign other_ok  = 32'(i_other_node) < 32'(NODE_COUNT);
    assign idx_node  = node_ok  ? NW'(i_node)       : '0;
    assign idx_other = other_ok ? NW'(i_other_node) : '0;

    // node 0 never gets written, so it reads as zero here
    assign dq0 = r_dz0 ? '0 : dep_q0;
    assign dq1 = r_dz1 ? '0 : dep_q1;
    assign aq0 = r_az0 ? '0 : (r_afwd ? r_afwd_data : anc_q0);
    assign aq1 = r_az1 ? '0 : anc_q1;

    assign o_in_stall  = (r_state != tdbl_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_up        = r_up;
        n_da        = r_da;
        n_lvl       = r_lvl;
        n_ret       = r_ret;
        n_out_valid = r_out_valid & i_out_stall;
        n_distance  = r_distance;

        dep_we    = 1'b0;
        dep_waddr = r_a;
        dep_wdata = '0;
        dep_ra0   = idx_node;
        dep_ra1   = idx_other;
        anc_we    = 1'b0;
        anc_waddr = {r_a, r_lvl};
        anc_wdata = '0;
        anc_ra0   = {r_a, r_lvl};
        anc_ra1   = {r_b, r_lvl};

        b_sel   = r_b;
        a_new   = r_a;
        b_new   = r_b;
        up_take = 1'b0;

        case (r_state)
            tdbl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_a   = idx_node;
                    n_b   = idx_other;
                    n_ret = '0;
                    if (i_opcode == tdbl_pkg::OP_QUERY) begin
                        n_state = tdbl_pkg::ST_Q_DEP;
                    end else if (i_node != '0 && node_ok) begin
                        n_state = tdbl_pkg::ST_L_DEP;
                    end
                end
            end

            tdbl_pkg::ST_L_DEP: begin
                dep_we    = 1'b1;
                dep_waddr = r_a;
                dep_wdata = (dq1 == tdbl_pkg::DEPTH_MAX) ? tdbl_pkg::DEPTH_MAX :
                            dq1 + tdbl_pkg::DEPTH_W'(1);
                anc_we    = 1'b1;
                anc_waddr = {r_a, LW'(0)};
                anc_wdata = r_b;
                anc_ra0   = {r_b, LW'(0)};
                n_lvl     = LW'(1);
                n_state   = tdbl_pkg::ST_L_ANC;
            end

            tdbl_pkg::ST_L_ANC: begin
                // aq0 is the 2^(lvl-1) ancestor of the 2^(lvl-1) ancestor
                anc_we    = 1'b1;
                anc_waddr = {r_a, r_lvl};
                anc_wdata = aq0;
                anc_ra0   = {aq0, r_lvl};
                if (r_lvl == LAST_LVL) begin
                    n_state = tdbl_pkg::ST_IDLE;
                end else begin
                    n_lvl = r_lvl + LW'(1);
                end
            end

            tdbl_pkg::ST_Q_DEP: begin
                n_lvl = LAST_LVL;
                if (dq0 != dq1) begin
                    // a ends up the shallower node, b is lifted
                    if (dq0 > dq1) begin
                        n_a   = r_b;
                        n_b   = r_a;
                        n_da  = dq1;
                        b_sel = r_a;
                    end else begin
                        n_da  = dq0;
                        b_sel = r_b;
                    end
                    anc_ra0 = {b_sel, LAST_LVL};
                    n_state = tdbl_pkg::ST_Q_UP;
                end else if (r_a == r_b) begin
                    n_state = tdbl_pkg::ST_Q_OUT;
                end else begin
                    anc_ra0 = {r_a, LAST_LVL};
                    anc_ra1 = {r_b, LAST_LVL};
                    n_state = tdbl_pkg::ST_Q_PAIR;
                end
            end

            tdbl_pkg::ST_Q_UP: begin
                n_up    = aq0;
                dep_ra0 = aq0;
                n_state = tdbl_pkg::ST_Q_UPD;
            end

            tdbl_pkg::ST_Q_UPD: begin
                up_take = (r_da <= dq0);
                b_new   = up_take ? r_up : r_b;
                n_b     = b_new;
                if (up_take) begin
                    n_ret = r_ret + (RW'(1) << r_lvl);
                end
                if (r_lvl != '0) begin
                    n_lvl   = r_lvl - LW'(1);
                    anc_ra0 = {b_new, r_lvl - LW'(1)};
                    n_state = tdbl_pkg::ST_Q_UP;
                end else if (r_a != b_new) begin
                    n_lvl   = LAST_LVL;
                    anc_ra0 = {r_a, LAST_LVL};
                    anc_ra1 = {b_new, LAST_LVL};
                    n_state = tdbl_pkg::ST_Q_PAIR;
                end else begin
                    n_state = tdbl_pkg::ST_Q_OUT;
                end
            end

            tdbl_pkg::ST_Q_PAIR: begin
                if (aq0 != aq1) begin
                    a_new = aq0;
                    b_new = aq1;
                    n_ret = r_ret + (RW'(2) << r_lvl);
                end
                n_a = a_new;
                n_b = b_new;
                if (r_lvl != '0) begin
                    n_lvl   = r_lvl - LW'(1);
                    anc_ra0 = {a_new, r_lvl - LW'(1)};
                    anc_ra1 = {b_new, r_lvl - LW'(1)};
                end else begin
                    // still apart below the common parent: one edge each side
                    if (a_new != b_new) begin
                        n_ret = n_ret + RW'(2);
                    end
                    n_state = tdbl_pkg::ST_Q_OUT;
                end
            end

            tdbl_pkg::ST_Q_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_distance  = (32'(r_ret) > 32'(tdbl_pkg::DIST_MAX)) ?
                                  tdbl_pkg::DIST_MAX : tdbl_pkg::DIST_W'(r_ret);
                    n_state     = tdbl_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tdbl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdbl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_up        <= n_up;
        r_da        <= n_da;
        r_lvl       <= n_lvl;
        r_ret       <= n_ret;
        r_distance  <= n_distance;
        r_dz0       <= (dep_ra0 == '0);
        r_dz1       <= (dep_ra1 == '0);
        r_az0       <= (anc_ra0[AW-1:LW] == '0);
        r_az1       <= (anc_ra1[AW-1:LW] == '0);
        r_afwd      <= anc_we && (anc_waddr == anc_ra0);
        r_afwd_data <= anc_wdata;
    end

endmodule
